@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the display idle dimmer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/did_pkg.sv @@
// Types and constants shared by the display idle dimmer modules.
package did_pkg;

    // Fade direction, encoded as reported on the result channel.
    typedef enum logic [1:0] {
        FADE_IDLE = 2'd0,
        FADE_DOWN = 2'd1,
        FADE_UP   = 2'd2
    } fade_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAX_BRIGHTNESS = 2'd0,
        CFG_IDLE_TIMEOUT   = 2'd1,
        CFG_DIM_ENABLE     = 2'd2,
        CFG_KEEP_ON        = 2'd3
    } cfg_index_t;

    localparam logic [1:0]         SLEEP_CLASS    = 2'd1;
    localparam logic [31:0]        STEP_GAP_MS    = 32'd19;
    localparam logic [7:0]         UP_STEP        = 8'd10;
    localparam logic [7:0]         DOWN_STEP      = 8'd5;
    localparam logic [7:0]         MIN_LEVEL      = 8'd1;
    localparam logic signed [10:0] COOL_TEMP      = 11'sd60;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_MAX_BRIGHTNESS = 8'd255;
    localparam logic [31:0] RST_IDLE_TIMEOUT   = 32'd15000;

    typedef struct packed {
        logic [7:0]  max_brightness;
        logic [31:0] idle_timeout_ms;
        logic        dim_enable;
        logic        keep_on_in_sleep;
    } did_cfg_t;

    typedef struct packed {
        logic               op;
        logic [31:0]        now_ms;
        logic [1:0]         mode_class;
        logic signed [10:0] tip_temp;
        logic               error_active;
    } did_item_t;

    typedef struct packed {
        fade_t       fade;
        logic        minimum_reached;
        logic [31:0] idle_stamp;
        logic [31:0] step_stamp;
        logic [7:0]  level;
        logic        power_flag;
    } did_state_t;

endpackage

@@ rtl/core/display_idle_dimmer.sv @@
// Top level of the display idle dimmer: channels, state and result register.
//
// Usage: each request on the s_ channel is one millisecond tick, optionally
// preceded by a wake (s_tuser high). The block answers every request with
// exactly one result on the m_ channel: brightness level, display power,
// fade direction and the minimum-reached flag after the update.
// Configuration is written through cfg_valid/cfg_index/cfg_data while no
// request is in flight; cfg_ready is always high.
// An accepted request is captured in the input register; its result is then
// captured in the result register and presented in m_tdata with m_tvalid
// high. Throughput: one request per cycle while the receiver takes results;
// the state update is a single pass of compare and add logic between the
// input register and the dimmer state and result registers.
// Reset (aresetn low, synchronous) restores full brightness 255, display
// on, no fade, and the default configuration. When the receiver stalls the
// result register holds; one more request is taken into the input register
// and then s_tready drops until the result is taken.
`include "assert_macros.svh"

module display_idle_dimmer (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // now_ms[31:0], mode_class[33:32],
                                   // tip_temp[44:34], error_active[45], zeros
    input  logic        s_tuser,   // op
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // brightness[7:0], display_on[8],
                                   // fade_state[10:9], at_minimum[11], zeros
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import did_pkg::*;

    did_cfg_t    cfg;
    did_item_t   item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    did_state_t  state_reg;
    did_state_t  state_next;
    logic [15:0] result_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        s_accept;
    logic        advance;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    did_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: the input register advances when the result register is free.
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_accept       = s_tvalid && s_tready;
    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // Input request register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.op           <= s_tuser;
            item_reg.now_ms       <= s_tdata[31:0];
            item_reg.mode_class   <= s_tdata[33:32];
            item_reg.tip_temp     <= $signed(s_tdata[44:34]);
            item_reg.error_active <= s_tdata[45];
        end
    end

    // State update for the request in the input register.
    did_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next)
    );

    // Valid flags and dimmer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.fade            <= FADE_IDLE;
            state_reg.minimum_reached <= 1'b0;
            state_reg.idle_stamp      <= '0;
            state_reg.step_stamp      <= '0;
            state_reg.level           <= RST_MAX_BRIGHTNESS;
            state_reg.power_flag      <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= {4'b0000, state_next.minimum_reached, state_next.fade,
                           state_next.power_flag, state_next.level};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // The minimum flag only stands with the minimum level.
    `ASSERT_ALWAYS(a_min_level, aclk, aresetn, m_tvalid && m_tdata[11] |-> m_tdata[7:0] == MIN_LEVEL, "minimum flag without minimum level")
    // The dimmer state moves only when a request is processed.
    `ASSERT_NEXT(a_state_hold, aclk, aresetn, !advance, $stable(state_reg), "state changed without a request")
    // A processed request always lands in the result register.
    `ASSERT_NEXT(a_result_valid, aclk, aresetn, advance, m_tvalid, "processed request lost")

endmodule

@@ rtl/core/did_cfg_regs.sv @@
// Configuration register bank of the display idle dimmer.
module did_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [31:0]         wr_data,
    output did_pkg::did_cfg_t   cfg
);
    import did_pkg::*;

    did_cfg_t cfg_reg;
    did_cfg_t cfg_next;

    // Decode a write request into the addressed register.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_index_t'(wr_index))
                CFG_MAX_BRIGHTNESS: cfg_next.max_brightness   = wr_data[7:0];
                CFG_IDLE_TIMEOUT:   cfg_next.idle_timeout_ms  = wr_data;
                CFG_DIM_ENABLE:     cfg_next.dim_enable       = wr_data[0];
                CFG_KEEP_ON:        cfg_next.keep_on_in_sleep = wr_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_brightness   <= RST_MAX_BRIGHTNESS;
            cfg_reg.idle_timeout_ms  <= RST_IDLE_TIMEOUT;
            cfg_reg.dim_enable       <= 1'b1;
            cfg_reg.keep_on_in_sleep <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/did_step.sv @@
// Next-state logic of the dimmer for one tick or wake request.
module did_step (
    input  did_pkg::did_item_t  item,
    input  did_pkg::did_state_t state,
    input  did_pkg::did_cfg_t   cfg,
    output did_pkg::did_state_t state_next
);
    import did_pkg::*;

    // A wake restarts the idle time and starts a fade up when one is useful.
    function automatic did_state_t wake(did_state_t st, logic [31:0] now,
                                        logic [7:0] max_level);
        did_state_t r;
        r = st;
        r.idle_stamp = now;
        if (st.fade != FADE_UP && st.level < max_level) begin
            r.power_flag      = 1'b1;
            r.fade            = FADE_UP;
            r.minimum_reached = 1'b0;
        end
        return r;
    endfunction

    did_state_t  after_op;
    did_state_t  after_wake;
    logic [31:0] idle_ms;
    logic [31:0] since_step;
    logic [8:0]  up_sum;
    logic        can_off;

    // Explicit wake first, then the automatic wake of a dark display above sleep.
    always_comb begin
        after_op   = item.op ? wake(state, item.now_ms, cfg.max_brightness) : state;
        after_wake = (!after_op.power_flag && item.mode_class > SLEEP_CLASS)
                   ? wake(after_op, item.now_ms, cfg.max_brightness) : after_op;
    end

    assign idle_ms    = item.now_ms - after_wake.idle_stamp;
    assign since_step = item.now_ms - after_wake.step_stamp;
    assign up_sum     = {1'b0, after_wake.level} + {1'b0, UP_STEP};
    assign can_off    = after_wake.minimum_reached
                      && idle_ms > {1'b0, cfg.idle_timeout_ms[31:1]}
                      && item.mode_class == SLEEP_CLASS && !cfg.keep_on_in_sleep
                      && (item.tip_temp < COOL_TEMP || item.error_active);

    // Idle timeout, power-off check and the fade steps.
    always_comb begin
        state_next = after_wake;
        if (after_wake.fade == FADE_IDLE) begin
            if (cfg.dim_enable) begin
                if (idle_ms > cfg.idle_timeout_ms) begin
                    state_next.fade = FADE_DOWN;
                end else if (can_off) begin
                    state_next.power_flag      = 1'b0;
                    state_next.minimum_reached = 1'b0;
                end
            end
        end else if (since_step > STEP_GAP_MS) begin
            state_next.step_stamp = item.now_ms;
            if (after_wake.fade == FADE_DOWN && after_wake.level > DOWN_STEP) begin
                state_next.level = after_wake.level - DOWN_STEP;
            end else if (after_wake.fade == FADE_UP
                         && up_sum < {1'b0, cfg.max_brightness}) begin
                state_next.level = up_sum[7:0];
            end else begin
                if (after_wake.fade == FADE_UP) begin
                    state_next.level = cfg.max_brightness;
                end else begin
                    state_next.level           = MIN_LEVEL;
                    state_next.minimum_reached = 1'b1;
                end
                state_next.idle_stamp = item.now_ms;
                state_next.fade       = FADE_IDLE;
            end
        end
    end

endmodule
